>>> hdl/ptw_pkg.sv
// Shared types and constants of the page table walker.
package ptw_pkg;

	typedef enum logic [0:0] {
		REQ_TRANSLATE = 1'b0,
		REQ_DATA      = 1'b1
	} req_kind_t;

	typedef enum logic [0:0] {
		OUT_READ = 1'b0,
		OUT_DONE = 1'b1
	} out_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LIMIT    = 2'd1,
		ST_INVALID  = 2'd2,
		ST_NO_INDEX = 2'd3
	} status_t;

	localparam logic [1:0] DT_NONE   = 2'd0;
	localparam logic [1:0] DT_PAGE   = 2'd1;
	localparam logic [1:0] DT_TABLE4 = 2'd2;
	localparam logic [1:0] DT_TABLE8 = 2'd3;

	localparam logic [0:0] REG_TRANSLATION_CONTROL = 1'b0;
	localparam logic [0:0] REG_ROOT_POINTER        = 1'b1;

	localparam logic [14:0] LIMIT_MAX = 15'h7FFF;

	typedef struct packed {
		req_kind_t   kind;
		logic        fault;
		status_t     fault_status;
		logic [31:0] read_addr;
		logic        read_long;
		logic [31:0] orig_addr;
		logic [31:0] shifted;
		logic [31:0] offset_mask;
		logic [15:0] widths;
		logic [63:0] data;
	} cmd_t;

	typedef struct packed {
		out_kind_t   out_type;
		logic [31:0] read_addr;
		logic        read_long;
		logic [31:0] physical_addr;
		logic [13:0] attributes;
		status_t     status;
	} result_t;

endpackage

>>> hdl/page_table_walker.sv
// Page table walker top level: configuration registers, queues, front and back parts.
// A translate request enters the command queue with its root-level lookup already
// decoded; the back part takes one queued request per cycle while the result queue
// is not full, so a request accepted into an empty block passes the command queue
// and the result queue in turn before its result is on the result ports. Requests
// stream at one per cycle as long as results are popped. Each descriptor read
// request goes out on the result queue; the walk advances when the descriptor data
// is pushed back, so walk speed is set by the round trip through the descriptor
// memory outside. A new translate request abandons any walk in progress;
// descriptor data that arrives while no walk is active is dropped without a result.
module page_table_walker #(
	parameter int LEVELS      = 4,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [31:0] logical_addr,
	input  logic [63:0] read_data,
	output logic        empty,
	input  logic        pop,
	output logic        out_type,
	output logic [31:0] read_addr,
	output logic        read_long,
	output logic [31:0] physical_addr,
	output logic [13:0] attributes,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);
	import ptw_pkg::*;

	logic [31:0] tc_q;
	logic [63:0] root_q;
	cmd_t        front_cmd, back_cmd;
	logic        cmd_empty, cmd_pop;
	logic        res_full, res_push;
	result_t     back_res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q   <= '0;
			root_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRANSLATION_CONTROL: tc_q   <= cfg_wdata[31:0];
				REG_ROOT_POINTER:        root_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ptw_front #(
		.LEVELS(LEVELS)
	) u_front (
		.req_type    (req_type),
		.logical_addr(logical_addr),
		.read_data   (read_data),
		.tc          (tc_q),
		.root        (root_q),
		.cmd         (front_cmd)
	);

	ptw_queue #(
		.item_t(cmd_t),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (front_cmd),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (back_cmd),
		.empty (cmd_empty)
	);

	ptw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (back_cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res)
	);

	ptw_queue #(
		.item_t(result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (back_res),
		.full  (res_full),
		.pop   (pop),
		.dout  (out_res),
		.empty (empty)
	);

	assign out_type      = out_res.out_type;
	assign read_addr     = out_res.read_addr;
	assign read_long     = out_res.read_long;
	assign physical_addr = out_res.physical_addr;
	assign attributes    = out_res.attributes;
	assign status        = out_res.status;

endmodule

>>> hdl/ptw_queue.sv
// Small first-in first-out queue of requests.
module ptw_queue #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output item_t dout,
	output logic  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/ptw_front.sv
// Front part: classifies requests and decodes the root level of a translation.
module ptw_front #(
	parameter int LEVELS = 4
) (
	input  logic              req_type,
	input  logic [31:0]       logical_addr,
	input  logic [63:0]       read_data,
	input  logic [31:0]       tc,
	input  logic [63:0]       root,
	output ptw_pkg::cmd_t     cmd
);
	import ptw_pkg::*;

	localparam int KEEP_SHIFT = 16 - 4 * (LEVELS - 1);
	localparam logic [15:0] WIDTH_KEEP = 16'(32'hFFFF << KEEP_SHIFT);

	logic [3:0]  init_shift, tia;
	logic [4:0]  consumed;
	logic [31:0] shifted0, idx32, root_addr;
	logic [14:0] idx, lo, hi, limit, idx_adj;
	logic [1:0]  dt;
	logic        long_desc;

	always_comb begin
		init_shift = tc[19:16];
		tia        = tc[15:12];
		consumed   = 5'({1'b0, init_shift}) + 5'({1'b0, tia});
		shifted0   = logical_addr << init_shift;
		idx32      = shifted0 >> (6'd32 - 6'({2'b0, tia}));
		idx        = idx32[14:0];
		limit      = root[62:48];
		dt         = root[33:32];
		root_addr  = {root[31:4], 4'b0};
		lo         = root[63] ? limit : '0;
		hi         = root[63] ? LIMIT_MAX : limit;
		idx_adj    = idx - lo;
		long_desc  = (dt == DT_TABLE8);

		cmd.kind         = req_kind_t'(req_type);
		cmd.fault        = 1'b0;
		cmd.fault_status = ST_OK;
		if (tia == 4'd0) begin
			cmd.fault        = 1'b1;
			cmd.fault_status = ST_NO_INDEX;
		end else if (idx < lo || idx > hi) begin
			cmd.fault        = 1'b1;
			cmd.fault_status = ST_LIMIT;
		end else if (dt == DT_NONE || dt == DT_PAGE) begin
			cmd.fault        = 1'b1;
			cmd.fault_status = ST_INVALID;
		end
		cmd.read_addr   = root_addr + (long_desc ? {14'b0, idx_adj, 3'b0}
			: {15'b0, idx_adj, 2'b0});
		cmd.read_long   = long_desc;
		cmd.orig_addr   = logical_addr;
		cmd.shifted     = logical_addr << consumed;
		cmd.offset_mask = 32'hFFFF_FFFF >> consumed;
		cmd.widths      = {tc[11:0], 4'b0} & WIDTH_KEEP;
		cmd.data        = read_data;
	end

endmodule

>>> hdl/ptw_back.sv
// Back part: holds the walk state and decodes one queued request per cycle while the result queue is not full.
module ptw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ptw_pkg::cmd_t     cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output ptw_pkg::result_t  res
);
	import ptw_pkg::*;

	logic        walking_q, long_q;
	logic [15:0] widths_q;
	logic [31:0] shifted_q, orig_q, mask_q;
	logic [13:0] attr_q;

	logic        walking_d, long_d;
	logic [15:0] widths_d;
	logic [31:0] shifted_d, orig_d, mask_d;
	logic [13:0] attr_d;

	logic [31:0] w0, w1, idx32, next_base;
	logic [1:0]  dt;
	logic [13:0] attr_page, attr_table;
	logic [3:0]  tia;
	logic [14:0] idx;
	logic        next_long;

	assign cmd_pop = !cmd_empty && !res_full;

	always_comb begin
		w0         = long_q ? cmd.data[63:32] : cmd.data[31:0];
		w1         = long_q ? cmd.data[31:0] : w0;
		dt         = w0[1:0];
		attr_page  = long_q ? w0[15:2] : {8'b0, w0[7:2]};
		attr_table = long_q ? w0[15:2] : {12'b0, w0[3:2]};
		tia        = widths_q[15:12];
		idx32      = shifted_q >> (6'd32 - 6'({2'b0, tia}));
		idx        = idx32[14:0];
		next_base  = {w1[31:2], 2'b0};
		next_long  = (dt == DT_TABLE8);

		walking_d = walking_q;
		long_d    = long_q;
		widths_d  = widths_q;
		shifted_d = shifted_q;
		orig_d    = orig_q;
		mask_d    = mask_q;
		attr_d    = attr_q;

		res_push          = 1'b0;
		res.out_type      = OUT_DONE;
		res.read_addr     = '0;
		res.read_long     = 1'b0;
		res.physical_addr = '0;
		res.attributes    = '0;
		res.status        = ST_OK;

		if (cmd_pop) begin
			if (cmd.kind == REQ_TRANSLATE) begin
				res_push = 1'b1;
				if (cmd.fault) begin
					walking_d  = 1'b0;
					res.status = cmd.fault_status;
				end else begin
					walking_d     = 1'b1;
					long_d        = cmd.read_long;
					widths_d      = cmd.widths;
					shifted_d     = cmd.shifted;
					orig_d        = cmd.orig_addr;
					mask_d        = cmd.offset_mask;
					attr_d        = '0;
					res.out_type  = OUT_READ;
					res.read_addr = cmd.read_addr;
					res.read_long = cmd.read_long;
				end
			end else if (walking_q) begin
				res_push = 1'b1;
				unique case (dt)
					DT_NONE: begin
						walking_d  = 1'b0;
						res.status = ST_INVALID;
					end
					DT_PAGE: begin
						walking_d         = 1'b0;
						attr_d            = attr_q | attr_page;
						res.physical_addr = {w1[31:8], 8'b0} | (orig_q & mask_q);
						res.attributes    = attr_d;
					end
					default: begin
						attr_d = attr_q | attr_table;
						if (tia == 4'd0) begin
							walking_d  = 1'b0;
							res.status = ST_NO_INDEX;
						end else begin
							shifted_d     = shifted_q << tia;
							mask_d        = mask_q >> tia;
							widths_d      = {widths_q[11:0], 4'b0};
							long_d        = next_long;
							res.out_type  = OUT_READ;
							res.read_long = next_long;
							res.read_addr = next_base + (next_long
								? {14'b0, idx, 3'b0} : {15'b0, idx, 2'b0});
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
			long_q    <= 1'b0;
			widths_q  <= '0;
			shifted_q <= '0;
			orig_q    <= '0;
			mask_q    <= '0;
			attr_q    <= '0;
		end else begin
			walking_q <= walking_d;
			long_q    <= long_d;
			widths_q  <= widths_d;
			shifted_q <= shifted_d;
			orig_q    <= orig_d;
			mask_q    <= mask_d;
			attr_q    <= attr_d;
		end
	end

	a_push_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> cmd_pop)
		else $error("result pushed without a request taken");

	a_stray_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.kind == REQ_DATA && !walking_q |-> !res_push)
		else $error("descriptor data outside a walk produced a result");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.out_type == OUT_DONE |=> !walking_q)
		else $error("walk still active after a finished translation");

	a_rise_on_translate: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(walking_q) |-> $past(cmd_pop && cmd.kind == REQ_TRANSLATE))
		else $error("walk started without a translate request");

endmodule
